>>> hw/rtl/urc_pkg.sv
// Shared types and constants for the ultrasonic range controller.
// No dependencies.
package urc_pkg;

	localparam int TRIG_W          = 8;
	localparam int DIST_W          = 29;
	localparam int COUNT_WIDTH_DEF = 24;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;
	localparam int IN_TDATA_W      = 8;
	localparam int OUT_TDATA_W     = 40;

	localparam logic [TRIG_W-1:0] TRIG_RESET = 8'd10;
	localparam logic [DIST_W-1:0] DIST_RESET = 29'd400000;

	// register index, taken from paddr[2]
	localparam logic REG_TRIGGER_TICKS = 1'b0;
	localparam logic REG_MAX_DISTANCE  = 1'b1;

	typedef struct packed {
		logic [TRIG_W-1:0] trigger_ticks;
		logic [DIST_W-1:0] range_limit;
	} cfg_t;

	typedef struct packed {
		logic              out_of_range;
		logic [DIST_W-1:0] distance;
		logic              result_valid;
		logic              busy_res;
		logic              trigger_level;
	} res_t;

endpackage

>>> hw/rtl/urc_apb_regs.sv
// APB register file: trigger length and distance limit.
// Depends on urc_pkg.
module urc_apb_regs import urc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [TRIG_W-1:0] trig_q;
	logic [DIST_W-1:0] maxd_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q <= TRIG_RESET;
			maxd_q <= DIST_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_TRIGGER_TICKS: trig_q <= pwdata[TRIG_W-1:0];
				REG_MAX_DISTANCE:  maxd_q <= pwdata[DIST_W-1:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TRIGGER_TICKS: prdata = {{(PDATA_W-TRIG_W){1'b0}}, trig_q};
			REG_MAX_DISTANCE:  prdata = {{(PDATA_W-DIST_W){1'b0}}, maxd_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.trigger_ticks = trig_q;
	assign cfg.range_limit   = maxd_q;

endmodule

>>> hw/rtl/urc_ping_fsm.sv
// Ping sequencer: trigger pulse, echo edge detect, width count and distance.
// Depends on urc_pkg.
module urc_ping_fsm import urc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic command,
	input  logic echo_level,
	input  cfg_t cfg,
	output res_t res
);

	localparam int PROD_W = (COUNT_WIDTH + 5 > DIST_W) ? COUNT_WIDTH + 5 : DIST_W;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_TRIG = 4'b0010,
		PH_WAIT = 4'b0100,
		PH_MEAS = 4'b1000
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
	logic                   echo_prev_q;
	logic [DIST_W-1:0]      dist_q, dist_d;
	logic                   flag_q, flag_d;
	logic                   trig, done;
	logic [PROD_W-1:0]      cnt_ext, prod, maxd_ext;

	assign cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
	assign cnt_ext  = PROD_W'(cnt_q);
	// x17 = x16 + x
	assign prod     = (cnt_ext << 4) + cnt_ext;
	assign maxd_ext = PROD_W'(cfg.range_limit);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		dist_d  = dist_q;
		flag_d  = flag_q;
		trig    = 1'b0;
		done    = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (command) begin
					phase_d = PH_TRIG;
					cnt_d   = COUNT_WIDTH'(1);
					trig    = 1'b1;
				end
			end
			PH_TRIG: begin
				if (cnt_q >= COUNT_WIDTH'(cfg.trigger_ticks)) begin
					phase_d = PH_WAIT;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_inc;
					trig  = 1'b1;
				end
			end
			PH_WAIT: begin
				if (echo_level && !echo_prev_q) begin
					phase_d = PH_MEAS;
					cnt_d   = COUNT_WIDTH'(1);
				end
			end
			PH_MEAS: begin
				if (echo_level) begin
					cnt_d = cnt_inc;
				end else begin
					if (prod <= maxd_ext) begin
						dist_d = prod[DIST_W-1:0];
						flag_d = 1'b0;
					end else begin
						dist_d = '0;
						flag_d = 1'b1;
					end
					phase_d = PH_IDLE;
					cnt_d   = '0;
					done    = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			echo_prev_q <= 1'b0;
			dist_q      <= '0;
			flag_q      <= 1'b0;
		end else if (en) begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			echo_prev_q <= echo_level;
			dist_q      <= dist_d;
			flag_q      <= flag_d;
		end
	end

	assign res.trigger_level = trig;
	assign res.busy_res      = (phase_d != PH_IDLE);
	assign res.result_valid  = done;
	assign res.distance      = dist_d;
	assign res.out_of_range  = flag_d;

endmodule

>>> hw/rtl/ultrasonic_range_controller_top.sv
// Ultrasonic range controller: input stage, ping sequencer and result register.
// A tick word is registered in the input stage, its result in the result
// register. Throughput: one tick word per cycle unless m_tready stalls the
// output; sequencer and x17 distance path are combinational between them.
// Reset (arst_n low, asynchronous): idle, counts and last result cleared,
// trigger_ticks = 10, max_distance = 400000. Depends on urc_pkg.
module ultrasonic_range_controller_top import urc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] command, [1] echo_level
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] trigger_level, [1] busy_res, [2] result_valid, [31:3] distance,
	// [32] out_of_range
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	output logic [PDATA_W-1:0]     prdata,
	output logic                   pready
);

	cfg_t cfg;
	res_t res;
	res_t res_q;
	logic valid_s1, cmd_s1, echo_s1;
	logic out_valid_q;
	logic adv, step;

	urc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv      = !out_valid_q || m_tready;
	assign step     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	urc_ping_fsm #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (step),
		.command    (cmd_s1),
		.echo_level (echo_s1),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tdata[0];
			echo_s1 <= s_tdata[1];
		end
		if (step)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-$bits(res_t)){1'b0}}, res_q};

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for ultrasonic_range_controller_top: tick words are streamed in
// bursts, every result word is checked against an in-bench ping sequencer model.
// Depends on urc_pkg and the top level RTL.
module testbench;
	import urc_pkg::*;

	localparam int COUNT_W     = COUNT_WIDTH_DEF;
	localparam int SOUND_X17   = 17;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 300;

	typedef struct packed {
		logic echo_level;
		logic command;
	} tick_word_t;

	typedef enum logic [1:0] {
		PING_IDLE, PING_TRIGGER, PING_WAIT_RISE, PING_MEASURE
	} ping_phase_e;

	typedef enum logic [1:0] {
		SINK_OPEN, SINK_SPARSE_STALL, SINK_EVERY_THIRD, SINK_MOSTLY_STALLED
	} sink_mode_e;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [0] command, [1] echo_level
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [0] trigger_level, [1] busy_res, [2] result_valid, [31:3] distance,
	// [32] out_of_range
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [PADDR_W-1:0]     paddr = '0;
	logic [PDATA_W-1:0]     pwdata = '0;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	// sequencer model state
	cfg_t               model_cfg = '{trigger_ticks: TRIG_RESET, range_limit: DIST_RESET};
	ping_phase_e        ping_phase = PING_IDLE;
	logic [COUNT_W-1:0] echo_count = '0;
	logic               echo_last = 1'b0;
	logic [DIST_W-1:0]  held_distance = '0;
	logic               held_oor = 1'b0;

	tick_word_t tick_q[$];
	res_t       result_q[$];
	int unsigned ticks_queued = 0;
	int unsigned ticks_sent = 0;
	int unsigned words_seen = 0;
	int unsigned pings_done = 0;
	int unsigned pings_oor = 0;
	int unsigned settings_used = 1;
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned stretch_left = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	sink_mode_e  sink_mode = SINK_OPEN;

	ultrasonic_range_controller_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// one tick of the sequencer; returns the result word it gives
	function automatic res_t advance_ping(input logic cmd, input logic echo);
		res_t        r;
		logic        trig;
		logic        done;
		logic [63:0] range_prod;
		trig = 1'b0;
		done = 1'b0;
		case (ping_phase)
			PING_IDLE: begin
				if (cmd) begin
					ping_phase = PING_TRIGGER;
					echo_count = COUNT_W'(1);
					trig = 1'b1;
				end
			end
			PING_TRIGGER: begin
				if (echo_count >= model_cfg.trigger_ticks) begin
					ping_phase = PING_WAIT_RISE;
					echo_count = '0;
				end else begin
					if (echo_count != '1)
						echo_count = echo_count + 1'b1;
					trig = 1'b1;
				end
			end
			PING_WAIT_RISE: begin
				if (echo && !echo_last) begin
					ping_phase = PING_MEASURE;
					echo_count = COUNT_W'(1);
				end
			end
			default: begin
				if (echo) begin
					if (echo_count != '1)
						echo_count = echo_count + 1'b1;
				end else begin
					range_prod = 64'(echo_count) * 64'(SOUND_X17);
					if (range_prod <= 64'(model_cfg.range_limit)) begin
						held_distance = range_prod[DIST_W-1:0];
						held_oor = 1'b0;
					end else begin
						held_distance = '0;
						held_oor = 1'b1;
					end
					ping_phase = PING_IDLE;
					echo_count = '0;
					done = 1'b1;
				end
			end
		endcase
		echo_last = echo;
		r.trigger_level = trig;
		r.busy_res = (ping_phase != PING_IDLE);
		r.result_valid = done;
		r.distance = held_distance;
		r.out_of_range = held_oor;
		return r;
	endfunction

	function automatic void queue_tick(input logic cmd, input logic echo);
		tick_q.push_back('{echo_level: echo, command: cmd});
		ticks_queued++;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, got %0d", field, want_v, got_v);
			mismatches++;
		end
	endtask

	// sender: bursts of random length, random gaps between them
	always @(posedge clk) begin : tick_driver
		logic       offer;
		tick_word_t next_tick;
		offer = s_tvalid;
		next_tick = tick_word_t'(s_tdata[1:0]);
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				result_q.push_back(advance_ping(next_tick.command, next_tick.echo_level));
				ticks_sent++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (tick_q.size() > 0) begin
					next_tick = tick_q.pop_front();
					offer = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else if ($urandom_range(0, 3) == 0) begin
						burst_left = $urandom_range(100, 300);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left = $urandom_range(0, 6);
					end
				end
			end
		end
		s_tvalid <= offer;
		s_tdata <= IN_TDATA_W'(next_tick);
	end

	// receiver: stall pattern changes every stretch, plus one long hold-off
	always @(posedge clk) begin : sink_pacing
		logic rdy;
		if (stretch_left == 0) begin
			sink_mode = sink_mode_e'($urandom_range(0, 3));
			stretch_left = $urandom_range(16, 96);
		end else begin
			stretch_left--;
		end
		if (!hold_done && words_seen >= HOLD_AFTER) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else begin
			case (sink_mode)
				SINK_OPEN:         rdy = 1'b1;
				SINK_SPARSE_STALL: rdy = ($urandom_range(0, 3) != 0);
				SINK_EVERY_THIRD:  rdy = (stretch_left % 3 != 0);
				default:           rdy = ($urandom_range(0, 3) == 0);
			endcase
		end
		m_tready <= rdy;
	end

	always @(posedge clk) begin : result_monitor
		res_t seen;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen = res_t'(m_tdata[$bits(res_t)-1:0]);
			words_seen++;
			if (result_q.size() == 0) begin
				$error("result word %h with nothing outstanding", m_tdata);
				mismatches++;
			end else begin
				want = result_q.pop_front();
				check_field("trigger_level", 32'(want.trigger_level), 32'(seen.trigger_level));
				check_field("busy_res", 32'(want.busy_res), 32'(seen.busy_res));
				check_field("result_valid", 32'(want.result_valid), 32'(seen.result_valid));
				check_field("distance", 32'(want.distance), 32'(seen.distance));
				check_field("out_of_range", 32'(want.out_of_range), 32'(seen.out_of_range));
				if (want.result_valid) begin
					pings_done++;
					if (want.out_of_range)
						pings_oor++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
		logic [31:0] readback;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == REG_TRIGGER_TICKS) begin
			model_cfg.trigger_ticks = value[TRIG_W-1:0];
			readback = 32'(value[TRIG_W-1:0]);
		end else begin
			model_cfg.range_limit = value[DIST_W-1:0];
			readback = 32'(value[DIST_W-1:0]);
		end
		@(posedge clk);
		psel <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("prdata", readback, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// all words accepted and answered, then the pipeline latency
	task automatic wait_idle();
		while (ticks_sent != ticks_queued || result_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// finish off a ping left hanging so that the sequencer is idle
	task automatic close_ping();
		wait_idle();
		while (ping_phase != PING_IDLE) begin
			if (ping_phase == PING_WAIT_RISE) begin
				queue_tick(1'b0, 1'b0);
				queue_tick(1'b0, 1'b1);
			end
			queue_tick(1'b0, 1'b0);
			wait_idle();
		end
	endtask

	task automatic add_ping(input int unsigned width_cap);
		int unsigned pulse_len;
		int unsigned low_len;
		int unsigned width;
		repeat ($urandom_range(0, 3))
			queue_tick(1'b0, 1'($urandom_range(0, 1)));
		queue_tick(1'b1, 1'($urandom_range(0, 1)));
		pulse_len = (model_cfg.trigger_ticks == 0) ? 1 : model_cfg.trigger_ticks;
		repeat (pulse_len)
			queue_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
		// now and then no low tick, so the echo may already be high
		low_len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
		repeat (low_len) queue_tick(1'b0, 1'b0);
		width = ($urandom_range(0, 9) == 0) ? $urandom_range(1, width_cap * 8)
			: $urandom_range(1, width_cap);
		repeat (width) queue_tick($urandom_range(0, 7) == 0, 1'b1);
		queue_tick(1'b0, 1'b0);
	endtask

	task automatic run_phase(input logic [31:0] trig, input logic [31:0] max_dist,
		input int unsigned target, input int unsigned width_cap);
		int unsigned first;
		cfg_write(REG_TRIGGER_TICKS, trig);
		cfg_write(REG_MAX_DISTANCE, max_dist);
		settings_used++;
		first = ticks_queued;
		while (ticks_queued - first < target) begin
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 8))
					queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				add_ping(width_cap);
			end
		end
		close_ping();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: idle reads zero, start and echo during the pulse,
		// echo already high at the end of the pulse
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b1);
		for (int i = 0; i < 9; i++)
			queue_tick(1'b1, 1'(i % 2));
		queue_tick(1'b0, 1'b1);
		queue_tick(1'b0, 1'b1);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b0, 1'b1);
		queue_tick(1'b0, 1'b0);
		close_ping();

		// zero-length pulse; distance exactly at the limit, then one step over
		cfg_write(REG_TRIGGER_TICKS, 32'd0);
		cfg_write(REG_MAX_DISTANCE, 32'd34);
		settings_used++;
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b0, 1'b1);
		queue_tick(1'b0, 1'b1);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b0, 1'b0);
		repeat (3) queue_tick(1'b0, 1'b1);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b0, 1'b0);
		close_ping();

		run_phase(32'd1, 32'd255, 200, 30);
		run_phase(32'd255, 32'd0, 100, 10);
		run_phase($urandom_range(2, 12), 32'd285212655, 180, 40);
		run_phase($urandom_range(1, 6), $urandom_range(0, 700), 180, 40);

		repeat (8) @(posedge clk);
		if (result_q.size() != 0) begin
			$error("%0d result words never arrived", result_q.size());
			mismatches++;
		end
		$display("Covered %0d tick words, %0d result words, %0d register settings.",
			ticks_sent, words_seen, settings_used);
		$display("Pings measured: %0d, of which %0d out of range.", pings_done, pings_oor);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
